/* sv/ost_pkg.sv */
package ost_pkg;

    localparam int TICK_W  = 3;
    localparam int SLOT_W  = 10;
    localparam int IDX_W   = TICK_W + SLOT_W;
    localparam int TICKERS = 1 << TICK_W;
    localparam int DEPTH   = 1 << IDX_W;

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(DEPTH - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT   = '1;
    localparam logic [TICK_W-1:0] LAST_TICKER = TICK_W'(TICKERS - 1);

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_PULL   = 1'b1;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_MODIFY = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LIVE     = 2'd1;
    localparam logic [1:0] ST_NOT_LIVE = 2'd2;
    localparam logic [1:0] ST_SIDE     = 2'd3;

    localparam logic [2:0] MSG_ACK   = 3'd0;
    localparam logic [2:0] MSG_START = 3'd1;
    localparam logic [2:0] MSG_CLEAR = 3'd2;
    localparam logic [2:0] MSG_ORDER = 3'd3;
    localparam logic [2:0] MSG_END   = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CLEAR = 2'd1,
        PH_SCAN  = 2'd2,
        PH_END   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_WR,
        OP_LOAD,
        OP_UPD_RD,
        OP_UPD_WR,
        OP_START,
        OP_CLEAR,
        OP_END,
        OP_SCAN_RD,
        OP_SCAN_CHK
    } op_t;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DISP,
        S_UPD_WR,
        S_SCAN_CHK
    } state_t;

    typedef struct packed {
        logic              req_type;
        logic [31:0]       seq_num;
        logic [1:0]        update_kind;
        logic [TICK_W-1:0] ticker;
        logic [SLOT_W-1:0] order_slot;
        logic              side_in;
        logic signed [31:0] price_in;
        logic [31:0]       qty_in;
        logic [31:0]       priority_in;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               seq_gap;
        logic [31:0]        msg_seq;
        logic [2:0]         msg_type;
        logic [TICK_W-1:0]  ticker_out;
        logic [31:0]        order_or_seq_out;
        logic               side_out;
        logic signed [31:0] price_out;
        logic [31:0]        qty_out;
        logic [31:0]        priority_out;
        logic               last_msg;
    } result_t;

    typedef struct packed {
        logic               live;
        logic               side;
        logic [31:0]        prio;
        logic signed [31:0] price;
        logic [31:0]        qty;
    } entry_t;

    typedef struct packed {
        logic   req_type;
        phase_t phase;
        logic   hit;
        logic   last_slot;
        logic   clr_done;
    } dp_status_t;

endpackage

/* sv/ost_ctrl.sv */
module ost_ctrl
    import ost_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t sts,
    output op_t        op,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.req_type == REQ_UPDATE)
                begin
                    state_next = S_UPD_WR;
                end
                else if (sts.phase == PH_SCAN)
                begin
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_UPD_WR:
            begin
                state_next = S_IDLE;
            end
            S_SCAN_CHK:
            begin
                if (sts.hit || sts.last_slot)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        op   = OP_NONE;
        busy = 1'b1;
        unique case (state_reg)
            S_CLR:
            begin
                op = OP_CLR_WR;
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    op = OP_LOAD;
                end
            end
            S_DISP:
            begin
                if (sts.req_type == REQ_UPDATE)
                begin
                    op = OP_UPD_RD;
                end
                else
                begin
                    unique case (sts.phase)
                        PH_IDLE:  op = OP_START;
                        PH_CLEAR: op = OP_CLEAR;
                        PH_SCAN:  op = OP_SCAN_RD;
                        PH_END:   op = OP_END;
                        default:  op = OP_NONE;
                    endcase
                end
            end
            S_UPD_WR:
            begin
                op = OP_UPD_WR;
            end
            S_SCAN_CHK:
            begin
                op = OP_SCAN_CHK;
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

endmodule

/* sv/ost_dp.sv */
module ost_dp
    import ost_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        op,
    input  item_t      item,
    output dp_status_t sts,
    output result_t    result,
    output logic       done
);

    entry_t             mem [DEPTH];
    entry_t             rd_reg;
    item_t              item_reg;
    logic [31:0]        last_seq_reg;
    logic [31:0]        last_seq_next;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [IDX_W-1:0]   cursor_reg;
    logic [IDX_W-1:0]   cursor_next;
    logic [31:0]        cnt_reg;
    logic [31:0]        cnt_next;
    logic [IDX_W-1:0]   clr_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               done_reg;
    logic               done_next;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic [IDX_W-1:0]   upd_idx;
    logic [IDX_W-1:0]   cursor_inc;
    logic [TICK_W-1:0]  cur_tick;
    logic [SLOT_W-1:0]  cur_slot;

    assign upd_idx    = {item_reg.ticker, item_reg.order_slot};
    assign cursor_inc = cursor_reg + 1'b1;
    assign cur_tick   = cursor_reg[IDX_W-1:SLOT_W];
    assign cur_slot   = cursor_reg[SLOT_W-1:0];

    assign sts.req_type  = item_reg.req_type;
    assign sts.phase     = phase_reg;
    assign sts.hit       = rd_reg.live;
    assign sts.last_slot = (cur_slot == LAST_SLOT);
    assign sts.clr_done  = (clr_reg == LAST_IDX);

    assign result = res_reg;
    assign done   = done_reg;

    always_comb
    begin
        we            = 1'b0;
        waddr         = upd_idx;
        wdata         = rd_reg;
        re            = 1'b0;
        raddr         = upd_idx;
        last_seq_next = last_seq_reg;
        phase_next    = phase_reg;
        cursor_next   = cursor_reg;
        cnt_next      = cnt_reg;
        res_next      = '0;
        done_next     = 1'b0;

        case (op)
            OP_CLR_WR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            OP_UPD_RD:
            begin
                re = 1'b1;
            end
            OP_UPD_WR:
            begin
                done_next         = 1'b1;
                res_next.msg_type = MSG_ACK;
                res_next.seq_gap  = (item_reg.seq_num != last_seq_reg + 32'd1);
                last_seq_next     = item_reg.seq_num;
                case (item_reg.update_kind)
                    KIND_ADD:
                    begin
                        if (rd_reg.live)
                        begin
                            res_next.status = ST_LIVE;
                        end
                        else
                        begin
                            we          = 1'b1;
                            wdata.live  = 1'b1;
                            wdata.side  = item_reg.side_in;
                            wdata.prio  = item_reg.priority_in;
                            wdata.price = item_reg.price_in;
                            wdata.qty   = item_reg.qty_in;
                        end
                    end
                    KIND_MODIFY, KIND_CANCEL:
                    begin
                        if (!rd_reg.live)
                        begin
                            res_next.status = ST_NOT_LIVE;
                        end
                        else if (rd_reg.side != item_reg.side_in)
                        begin
                            res_next.status = ST_SIDE;
                        end
                        else if (item_reg.update_kind == KIND_MODIFY)
                        begin
                            we          = 1'b1;
                            wdata.price = item_reg.price_in;
                            wdata.qty   = item_reg.qty_in;
                        end
                        else
                        begin
                            we         = 1'b1;
                            wdata.live = 1'b0;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
            end
            OP_START:
            begin
                done_next                 = 1'b1;
                res_next.msg_type         = MSG_START;
                res_next.msg_seq          = '0;
                res_next.order_or_seq_out = last_seq_reg;
                cnt_next                  = 32'd1;
                cursor_next               = '0;
                phase_next                = PH_CLEAR;
            end
            OP_CLEAR:
            begin
                done_next           = 1'b1;
                res_next.msg_type   = MSG_CLEAR;
                res_next.msg_seq    = cnt_reg;
                res_next.ticker_out = cur_tick;
                cnt_next            = cnt_reg + 32'd1;
                phase_next          = PH_SCAN;
            end
            OP_END:
            begin
                done_next                 = 1'b1;
                res_next.msg_type         = MSG_END;
                res_next.msg_seq          = cnt_reg;
                res_next.order_or_seq_out = last_seq_reg;
                res_next.last_msg         = 1'b1;
                cnt_next                  = cnt_reg + 32'd1;
                cursor_next               = '0;
                phase_next                = PH_IDLE;
            end
            OP_SCAN_RD:
            begin
                re    = 1'b1;
                raddr = cursor_reg;
            end
            OP_SCAN_CHK:
            begin
                if (rd_reg.live)
                begin
                    // report this order, then step past it
                    done_next                 = 1'b1;
                    res_next.msg_type         = MSG_ORDER;
                    res_next.msg_seq          = cnt_reg;
                    res_next.ticker_out       = cur_tick;
                    res_next.order_or_seq_out = 32'(cur_slot);
                    res_next.side_out         = rd_reg.side;
                    res_next.price_out        = rd_reg.price;
                    res_next.qty_out          = rd_reg.qty;
                    res_next.priority_out     = rd_reg.prio;
                    cnt_next                  = cnt_reg + 32'd1;
                    if (cur_slot != LAST_SLOT)
                    begin
                        cursor_next = cursor_inc;
                    end
                    else if (cur_tick != LAST_TICKER)
                    begin
                        cursor_next = cursor_inc;
                        phase_next  = PH_CLEAR;
                    end
                    else
                    begin
                        phase_next = PH_END;
                    end
                end
                else if (cur_slot != LAST_SLOT)
                begin
                    re          = 1'b1;
                    raddr       = cursor_inc;
                    cursor_next = cursor_inc;
                end
                else if (cur_tick != LAST_TICKER)
                begin
                    // empty rest of ticker: clear for the next one
                    done_next           = 1'b1;
                    res_next.msg_type   = MSG_CLEAR;
                    res_next.msg_seq    = cnt_reg;
                    res_next.ticker_out = cur_tick + 1'b1;
                    cnt_next            = cnt_reg + 32'd1;
                    cursor_next         = cursor_inc;
                    phase_next          = PH_SCAN;
                end
                else
                begin
                    done_next                 = 1'b1;
                    res_next.msg_type         = MSG_END;
                    res_next.msg_seq          = cnt_reg;
                    res_next.order_or_seq_out = last_seq_reg;
                    res_next.last_msg         = 1'b1;
                    cnt_next                  = cnt_reg + 32'd1;
                    cursor_next               = '0;
                    phase_next                = PH_IDLE;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
        if (op == OP_LOAD)
        begin
            item_reg <= item;
        end
        if (done_next)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= '0;
            phase_reg    <= PH_IDLE;
            cursor_reg   <= '0;
            cnt_reg      <= '0;
            clr_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            last_seq_reg <= last_seq_next;
            phase_reg    <= phase_next;
            cursor_reg   <= cursor_next;
            cnt_reg      <= cnt_next;
            done_reg     <= done_next;
            if (op == OP_CLR_WR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held two cycles");

    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.last_msg) |-> (res_reg.msg_type == MSG_END))
        else $error("last flag on a message other than end");

    a_end_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_END) |-> (cursor_reg == LAST_IDX))
        else $error("end phase with cursor off the last entry");

    a_clear_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CLEAR) |-> (cur_slot == '0))
        else $error("clear phase with cursor inside a ticker");
`endif

endmodule

/* sv/order_snapshot_table.sv */
// update: item registered on acceptance, then table read, then write-back; result strobe and busy low together
// start, clear and end pulls: result strobe after the dispatch state; the next item is taken back in idle
// order pulls: dispatch read, then one check per table slot scanned, bounded by the 1024 slots of a ticker
// the scan is limited by the single read port of the table memory, one entry per cycle
// reset: async active low; a clearing pass then zeroes all 8192 table entries with busy high
// results come out as a one-cycle done strobe; the receiver cannot stall
module order_snapshot_table
    import ost_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    // command from controller to datapath, one per cycle
    op_t        op;
    // walk phase, live hit and scan position back to the controller
    dp_status_t sts;

    // sequencing: clearing pass, dispatch, read-modify-write, scan loop
    ost_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .op    (op),
        .busy  (busy)
    );

    // table memory, walk registers and the result register
    ost_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .item   (item),
        .sts    (sts),
        .result (result),
        .done   (done)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ost_pkg::*;

    localparam int SLOTS = 1 << SLOT_W;
    localparam longint CYCLE_LIMIT = 10000000;

    // one table entry as the checker sees it
    typedef struct {
        bit       live;
        bit       side;
        bit [31:0] prio;
        bit [31:0] price;
        bit [31:0] qty;
    } book_entry_t;

    // scoreboard: mirrors the order table and the snapshot walk, holds pending acks and messages
    class book_scoreboard;
        book_entry_t book[DEPTH];
        bit [31:0]   last_seq;
        phase_t      phase;
        int unsigned cursor;
        bit [31:0]   msg_count;
        result_t     pending[$];
        int          errors;
        int          acks;
        int          orders_seen;
        int          snapshots;

        function void clear_all();
            foreach (book[i]) book[i].live = 0;
            last_seq = 0;
            phase = PH_IDLE;
            cursor = 0;
            msg_count = 0;
            pending.delete();
        endfunction

        function void emit_end(ref result_t r);
            r.msg_seq = msg_count;
            msg_count++;
            r.msg_type = MSG_END;
            r.order_or_seq_out = last_seq;
            r.last_msg = 1;
            phase = PH_IDLE;
            cursor = 0;
            snapshots++;
        endfunction

        // apply one accepted transfer and queue the result it must produce
        function void note_item(item_t it);
            result_t r;
            int unsigned idx;
            int unsigned tk;
            int unsigned stop;
            bit found;
            r = '0;
            if (it.req_type == REQ_UPDATE) begin
                idx = 32'({it.ticker, it.order_slot});
                if (it.update_kind == KIND_ADD) begin
                    if (book[idx].live) r.status = ST_LIVE;
                    else begin
                        book[idx].live = 1;
                        book[idx].side = it.side_in;
                        book[idx].prio = it.priority_in;
                        book[idx].price = it.price_in;
                        book[idx].qty = it.qty_in;
                    end
                end else if (it.update_kind == KIND_MODIFY || it.update_kind == KIND_CANCEL) begin
                    if (!book[idx].live) r.status = ST_NOT_LIVE;
                    else if (book[idx].side != it.side_in) r.status = ST_SIDE;
                    else if (it.update_kind == KIND_MODIFY) begin
                        book[idx].price = it.price_in;
                        book[idx].qty = it.qty_in;
                    end else book[idx].live = 0;
                end
                r.seq_gap = (it.seq_num != last_seq + 32'd1);
                r.msg_type = MSG_ACK;
                last_seq = it.seq_num;
                acks++;
            end else if (phase == PH_END) begin
                emit_end(r);
            end else if (phase == PH_IDLE) begin
                msg_count = 1;
                r.msg_seq = 0;
                r.msg_type = MSG_START;
                r.order_or_seq_out = last_seq;
                cursor = 0;
                phase = PH_CLEAR;
            end else if (phase == PH_CLEAR) begin
                r.msg_seq = msg_count;
                msg_count++;
                r.msg_type = MSG_CLEAR;
                r.ticker_out = TICK_W'(cursor / SLOTS);
                phase = PH_SCAN;
            end else begin
                // scan the cursor's ticker for the next live order
                tk = cursor / SLOTS;
                stop = (tk + 1) * SLOTS;
                found = 0;
                for (int unsigned i = cursor; i < stop && !found; i++) begin
                    if (book[i].live) begin
                        found = 1;
                        r.msg_seq = msg_count;
                        msg_count++;
                        r.msg_type = MSG_ORDER;
                        r.ticker_out = TICK_W'(tk);
                        r.order_or_seq_out = i - tk * SLOTS;
                        r.side_out = book[i].side;
                        r.price_out = book[i].price;
                        r.qty_out = book[i].qty;
                        r.priority_out = book[i].prio;
                        orders_seen++;
                        cursor = i + 1;
                        if (i + 1 >= stop) begin
                            // last slot of a ticker taken
                            if (tk + 1 < TICKERS) begin
                                cursor = stop;
                                phase = PH_CLEAR;
                            end else begin
                                cursor = stop - 1;
                                phase = PH_END;
                            end
                        end
                    end
                end
                if (!found) begin
                    if (tk + 1 < TICKERS) begin
                        cursor = stop;
                        r.msg_seq = msg_count;
                        msg_count++;
                        r.msg_type = MSG_CLEAR;
                        r.ticker_out = TICK_W'(tk + 1);
                        phase = PH_SCAN;
                    end else emit_end(r);
                end
            end
            pending.push_back(r);
        endfunction

        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status) report_mismatch("status", got.status, want.status);
            if (got.seq_gap != want.seq_gap) report_mismatch("seq_gap", got.seq_gap, want.seq_gap);
            if (got.msg_seq != want.msg_seq) report_mismatch("msg_seq", got.msg_seq, want.msg_seq);
            if (got.msg_type != want.msg_type)
                report_mismatch("msg_type", got.msg_type, want.msg_type);
            if (got.ticker_out != want.ticker_out)
                report_mismatch("ticker_out", got.ticker_out, want.ticker_out);
            if (got.order_or_seq_out != want.order_or_seq_out)
                report_mismatch("order_or_seq_out", got.order_or_seq_out, want.order_or_seq_out);
            if (got.side_out != want.side_out)
                report_mismatch("side_out", got.side_out, want.side_out);
            if (got.price_out != want.price_out)
                report_mismatch("price_out", got.price_out, want.price_out);
            if (got.qty_out != want.qty_out) report_mismatch("qty_out", got.qty_out, want.qty_out);
            if (got.priority_out != want.priority_out)
                report_mismatch("priority_out", got.priority_out, want.priority_out);
            if (got.last_msg != want.last_msg)
                report_mismatch("last_msg", got.last_msg, want.last_msg);
        endtask
    endclass

    logic    clk = 0;
    logic    rst_n = 0;
    logic    start = 0;
    item_t   item = '0;
    logic    busy;
    logic    done;
    result_t result;

    book_scoreboard sb;
    longint cycles = 0;
    int     mismatches = 0;
    int     items_sent = 0;
    bit [31:0] seq_run = 0;

    // live orders the stimulus knows of, so most modifies and cancels hit
    bit [IDX_W-1:0] known[$];
    bit             known_side[$];

    order_snapshot_table uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    // results are taken at the rising edge, no stall possible
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && done) sb.check_result(result);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // drive one transfer from a falling edge, hold until accepted
    // start stays high after acceptance, the block is busy right after a transfer
    task automatic send_item(item_t it);
        item <= it;
        start <= 1;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        sb.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        start <= 0;
        repeat (n) @(negedge clk);
    endtask

    function automatic item_t rand_item();
        item_t it;
        it.req_type    = REQ_UPDATE;
        it.seq_num     = $urandom;
        it.update_kind = 2'($urandom_range(0, 3));
        it.ticker      = TICK_W'($urandom_range(0, TICKERS - 1));
        it.order_slot  = SLOT_W'($urandom);
        it.side_in     = 1'($urandom_range(0, 1));
        it.price_in    = $urandom;
        it.qty_in      = $urandom;
        it.priority_in = $urandom;
        return it;
    endfunction

    function automatic item_t make_update(bit [1:0] kind, bit [TICK_W-1:0] tk,
                                          bit [SLOT_W-1:0] slot, bit sd);
        item_t it;
        it = rand_item();
        seq_run++;
        it.seq_num = ($urandom_range(0, 19) == 0) ? $urandom : seq_run;
        seq_run = it.seq_num;
        it.update_kind = kind;
        it.ticker = tk;
        it.order_slot = slot;
        it.side_in = sd;
        return it;
    endfunction

    function automatic item_t make_pull();
        item_t it;
        it = rand_item();
        it.req_type = REQ_PULL;
        return it;
    endfunction

    task automatic wait_drained();
        start <= 0;
        @(negedge clk);
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    // a market update: mostly adds, modifies and cancels of live ones, with some random noise
    task automatic send_market_update();
        item_t it;
        int k;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40 || known.size() == 0) begin
            it = make_update(KIND_ADD, TICK_W'($urandom_range(0, TICKERS - 1)),
                             SLOT_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(0, 15)),
                             1'($urandom_range(0, 1)));
            if (!sb.book[{it.ticker, it.order_slot}].live) begin
                known.push_back({it.ticker, it.order_slot});
                known_side.push_back(it.side_in);
            end
        end else if (pick < 85) begin
            k = $urandom_range(0, known.size() - 1);
            it = make_update(($urandom_range(0, 1) == 0) ? KIND_MODIFY : KIND_CANCEL,
                             known[k][IDX_W-1:SLOT_W], known[k][SLOT_W-1:0],
                             ($urandom_range(0, 9) == 0) ? ~known_side[k] : known_side[k]);
            if (it.update_kind == KIND_CANCEL && it.side_in == known_side[k]) begin
                known.delete(k);
                known_side.delete(k);
            end
        end else begin
            // noise: random kind and slot, may fail its checks
            it = make_update(2'($urandom_range(0, 3)), TICK_W'($urandom_range(0, TICKERS - 1)),
                             SLOT_W'($urandom), 1'($urandom_range(0, 1)));
        end
        send_item(it);
    endtask

    initial begin
        item_t it;
        int burst;
        sb = new();
        sb.clear_all();
        idle_cycles(10);
        rst_n <= 1;

        // directed: field extremes, every kind, every failure, a full walk
        it = make_update(KIND_ADD, 0, 0, 0);
        it.price_in = 32'h8000_0000; it.qty_in = 0; it.priority_in = '1;
        send_item(it);
        it = make_update(KIND_ADD, LAST_TICKER, LAST_SLOT, 1);
        it.price_in = 32'h7fff_ffff; it.qty_in = '1; it.priority_in = 0;
        send_item(it);
        known.push_back({LAST_TICKER, LAST_SLOT}); known_side.push_back(1'b1);
        send_item(make_update(KIND_ADD, 0, 0, 1));           // add to a live slot
        send_item(make_update(KIND_MODIFY, 3, 5, 0));        // slot not live
        send_item(make_update(KIND_CANCEL, 0, 0, 1));        // side mismatch
        send_item(make_update(KIND_MODIFY, 0, 0, 0));
        send_item(make_update(KIND_OTHER, 2, 2, 1));         // other kind
        it = make_update(KIND_ADD, 4, 7, 0); it.seq_num = '1; send_item(it);
        it = make_update(KIND_ADD, 4, 8, 1); it.seq_num = 0; send_item(it);  // wrap, no gap
        seq_run = 0;
        it = make_update(KIND_ADD, 4, 9, 1); it.seq_num = 77; send_item(it);  // gap
        seq_run = 77;
        repeat (24) send_item(make_pull());                  // walk through the end
        send_item(make_update(KIND_CANCEL, 4, 7, 0));
        repeat (3) send_item(make_pull());
        wait_drained();
        idle_cycles(40);

        // random: bursts of updates with walks interleaved, random gaps
        while (items_sent < 1350) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                if ($urandom_range(0, 99) < 35) send_item(make_pull());
                else if ($urandom_range(0, 19) == 0) send_item(rand_item());
                else send_market_update();
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
            else if ($urandom_range(0, 1) == 0) idle_cycles($urandom_range(1, 12));
        end

        wait_drained();
        idle_cycles(2200);
        $display("sent %0d transfers: %0d updates, %0d order messages, %0d snapshots completed",
                 items_sent, sb.acks, sb.orders_seen, sb.snapshots);
        if (mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/ost_pkg.sv
sv/ost_ctrl.sv
sv/ost_dp.sv
sv/order_snapshot_table.sv
test/tb_top.sv
